// ===== rtl/core/fpfe_pkg.sv =====
// Shared types, register indexes and frame helpers for the flip-dot frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package fpfe_pkg;

  localparam int MAX_MODULES = 8;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [2:0] REG_MODULE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_MODULE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_MODULE_COUNT   = 3'd2;
  localparam logic [2:0] REG_SET_PULSE_US   = 3'd3;
  localparam logic [2:0] REG_RESET_PULSE_US = 3'd4;

  localparam logic FRAME_SELECT = 1'b0;
  localparam logic FRAME_DRIVE  = 1'b1;

  typedef struct packed {
    logic [4:0]  mod_cols;
    logic [4:0]  mod_rows;
    logic [3:0]  module_count;
    logic [15:0] set_pulse_us;
    logic [15:0] reset_pulse_us;
  } cfg_t;

  // One classified pixel command waiting for the back end
  typedef struct packed {
    logic [3:0] module_num;
    logic [4:0] col;
    logic [4:0] row;
    logic       show;
    logic       hold;
  } cmd_t;

  // Column address with a gap after each of the first three groups of seven columns
  function automatic logic [5:0] column_code(input logic [4:0] col);
    logic [5:0] c;
    begin
      c = {1'b0, col} + 6'd1;
      if (c <= 6'd7) return c;
      else if (c <= 6'd14) return c + 6'd1;
      else if (c <= 6'd21) return c + 6'd2;
      else return c + 6'd3;
    end
  endfunction

  function automatic logic [7:0] status_byte(input logic [4:0] col, input logic show);
    logic [5:0] code;
    begin
      code = column_code(col);
      return {~code[4:0], 3'b000} | (show ? 8'h02 : 8'h00);
    end
  endfunction

  // Rows past the 16-bit driver word get no bit
  function automatic logic [15:0] row_word(input logic [4:0] row);
    begin
      if (row < 5'd16) return 16'h0001 << row[3:0];
      else return 16'h0000;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fpfe_front.sv =====
// Front end: accepts pixel commands, checks range and splits x into module and column.
`timescale 1ns / 1ps
`default_nettype none
module fpfe_front import fpfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic       show,
  input  wire logic       hold,
  output logic            push,
  output cmd_t            push_data,
  input  wire logic       full
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic       state;
  logic [7:0] rem;
  logic [2:0] quot;
  logic [4:0] row;
  logic       show_r;
  logic       hold_r;

  logic [3:0] count_eff;
  logic [8:0] disp_cols;
  logic       in_range;
  logic       accept;
  logic       rem_ge;

  always_comb begin
    count_eff = (cfg.module_count > 4'(MAX_MODULES)) ? 4'(MAX_MODULES) : cfg.module_count;
    disp_cols = 9'(cfg.mod_cols) * 9'(count_eff);
    in_range  = ({1'b0, pos_x} < disp_cols) && (pos_y < {3'b000, cfg.mod_rows});
    accept    = in_valid && !in_stall;
    rem_ge    = rem >= {3'b000, cfg.mod_cols};
  end

  assign in_stall = (state != ST_IDLE);
  assign push     = (state == ST_DIV) && !rem_ge && !full;

  always_comb begin
    push_data.module_num = {1'b0, quot} + 4'd1;
    push_data.col        = rem[4:0];
    push_data.row        = row;
    push_data.show       = show_r;
    push_data.hold       = hold_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          // drop commands outside the display
          if (accept && in_range) state <= ST_DIV;
        end
        ST_DIV: begin
          if (push) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Repeated subtraction: at most MAX_MODULES-1 steps since x is in range
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (accept) begin
        rem    <= pos_x;
        quot   <= 3'd0;
        row    <= pos_y[4:0];
        show_r <= show;
        hold_r <= hold;
      end
    end else if (rem_ge) begin
      rem  <= rem - {3'b000, cfg.mod_cols};
      quot <= quot + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fpfe_queue.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module fpfe_queue import fpfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fpfe_back.sv =====
// Back end: tracks the selected module and builds select and drive frames.
`timescale 1ns / 1ps
`default_nettype none
module fpfe_back import fpfe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire cmd_t head,
  input  wire logic empty,
  output logic      pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic        frame_kind,
  output logic [39:0] frame_bits,
  output logic [15:0] pulse_us,
  output logic        keep_enabled,
  output logic        last
);

  logic [3:0]  current_module;
  logic        load;
  logic        need_select;
  logic [15:0] row;
  logic [7:0]  status;
  logic [7:0]  select_byte;
  logic [2:0]  module_idx;

  always_comb begin
    load        = !out_valid || !out_stall;
    need_select = head.module_num != current_module;
    row         = row_word(head.row);
    status      = status_byte(head.col, head.show);
    module_idx  = 3'(head.module_num - 4'd1);
    select_byte = 8'h01 << module_idx;
  end

  // A command leaves the queue with its drive frame; a select frame comes first when needed
  assign pop = load && !empty && !need_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      current_module <= 4'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty && need_select) current_module <= head.module_num;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      if (need_select) begin
        frame_kind   <= FRAME_SELECT;
        frame_bits   <= {32'h0, select_byte};
        pulse_us     <= 16'h0000;
        keep_enabled <= 1'b0;
        last         <= 1'b0;
      end else begin
        frame_kind <= FRAME_DRIVE;
        if (head.show) begin
          frame_bits <= {row, 16'h0000, status};
        end else begin
          frame_bits <= {16'h0000, row, status};
        end
        if (head.hold) pulse_us <= 16'h0000;
        else pulse_us <= head.show ? cfg.set_pulse_us : cfg.reset_pulse_us;
        keep_enabled <= head.hold;
        last         <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/flipdot_pixel_frame_encoder.sv =====
// Top level of the flip-dot pixel frame encoder: config registers, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted pixel command yields nothing (outside the display), one drive
// frame, or a module select frame followed by a drive frame; last marks the
// drive frame. A command outside the display is taken and dropped without
// stalling the input. A command on the display is accepted and range-checked,
// then holds the input through one subtract-and-compare step per module passed
// while dividing x by the columns per module and through the hand-over of the
// command to a two-entry queue; that hand-over waits while the queue is full.
// The back end sends one frame per cycle from its output register while the
// receiver does not stall. Configuration writes are always ready and must only
// happen while the block is idle.
module flipdot_pixel_frame_encoder import fpfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic        show,
  input  wire logic        hold,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             frame_kind,
  output logic [39:0]      frame_bits,
  output logic [15:0]      pulse_us,
  output logic             keep_enabled,
  output logic             last
);

  cfg_t cfg;
  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mod_cols       <= 5'd28;
      cfg.mod_rows       <= 5'd16;
      cfg.module_count   <= 4'd1;
      cfg.set_pulse_us   <= 16'h0000;
      cfg.reset_pulse_us <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULE_WIDTH:   cfg.mod_cols       <= cfg_data[4:0];
        REG_MODULE_HEIGHT:  cfg.mod_rows       <= cfg_data[4:0];
        REG_MODULE_COUNT:   cfg.module_count   <= cfg_data[3:0];
        REG_SET_PULSE_US:   cfg.set_pulse_us   <= cfg_data;
        REG_RESET_PULSE_US: cfg.reset_pulse_us <= cfg_data;
        default: ;
      endcase
    end
  end

  fpfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .show      (show),
    .hold      (hold),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  fpfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  fpfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .frame_bits   (frame_bits),
    .pulse_us     (pulse_us),
    .keep_enabled (keep_enabled),
    .last         (last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_flipdot_pixel_frame_encoder.sv =====
// Self-checking testbench for the flip-dot pixel frame encoder.
`timescale 1ns / 1ps
module tb_flipdot_pixel_frame_encoder;
  import fpfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  // Allowance for the front end's division, then queue and output register
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 380;
  localparam int PHASE_ITEMS   = 45;

  typedef struct packed {
    logic        kind;
    logic [39:0] bits;
    logic [15:0] pulse;
    logic        keep;
    logic        last;
  } frame_t;

  typedef enum logic [1:0] {ROW_REG, ROW_PIX, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [15:0] data;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        s;
    logic        h;
    logic [1:0]  nres;
    logic [7:0]  sel;
    logic [39:0] drv;
    logic [15:0] pulse;
    logic        keep;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_MODULE_WIDTH;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pos_x = 8'h00;
  logic [7:0]  pos_y = 8'h00;
  logic        show = 1'b0;
  logic        hold = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_kind;
  logic [39:0] frame_bits;
  logic [15:0] pulse_us;
  logic        keep_enabled;
  logic        last;

  // Predictor state: register copy and selected module
  cfg_t        regs_now;
  logic [3:0]  sel_module;
  frame_t      next_frames [2];
  int          next_count;

  frame_t      frames_due [$];
  int          errors = 0;
  int          frames_checked = 0;
  int          pixels_sent = 0;
  int          pixels_drawn = 0;
  int          reg_writes = 0;
  int unsigned cycle_count = 0;
  logic [1:0]  stall_mode = 2'd0;

  flipdot_pixel_frame_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .show         (show),
    .hold         (hold),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .frame_bits   (frame_bits),
    .pulse_us     (pulse_us),
    .keep_enabled (keep_enabled),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d frames outstanding",
               cycle_count, frames_due.size());
      $display("flipdot_pixel_frame_encoder test failed");
      $finish;
    end
  end

  // Receiver stall pattern: none, random or periodic bursts; the mode is re-chosen from the cycle counter
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cycle_count % 13) < 7;
    endcase
  end

  task automatic flag_mismatch(input string what, input logic [39:0] got, want);
    errors++;
    $display("mismatch at frame %0d, %s: got 0x%0h, expected 0x%0h",
             frames_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        flag_mismatch("frame with none expected", frame_bits, 40'h0);
      end else begin
        want = frames_due.pop_front();
        if (frame_kind !== want.kind) flag_mismatch("frame_kind", frame_kind, want.kind);
        if (frame_bits !== want.bits) flag_mismatch("frame_bits", frame_bits, want.bits);
        if (pulse_us !== want.pulse) flag_mismatch("pulse_us", pulse_us, want.pulse);
        if (keep_enabled !== want.keep)
          flag_mismatch("keep_enabled", keep_enabled, want.keep);
        if (last !== want.last) flag_mismatch("last", last, want.last);
      end
      frames_checked++;
    end
  end

  // Work out the frames one pixel command yields and advance the module selection
  function automatic void predict_pixel(input logic [7:0] x, y, input logic s, h);
    int unsigned mods, span, mod_num, col;
    logic [5:0]  code;
    logic [7:0]  status;
    logic [15:0] row;
    logic [39:0] bits;
    logic [15:0] pulse;
    next_count = 0;
    next_frames[0] = '0;
    next_frames[1] = '0;
    mods = (regs_now.module_count > MAX_MODULES) ? MAX_MODULES : regs_now.module_count;
    span = regs_now.mod_cols * mods;
    if (regs_now.mod_cols == 0 || x >= span || y >= regs_now.mod_rows) return;
    mod_num = x / regs_now.mod_cols + 1;
    col = x % regs_now.mod_cols;
    if (sel_module != mod_num) begin
      next_frames[0] = '{FRAME_SELECT, 40'(1 << (mod_num - 1)), 16'h0000, 1'b0, 1'b0};
      next_count = 1;
      sel_module = 4'(mod_num);
    end
    // one skipped code after each group of seven columns, at most three
    code = 6'(col + 1 + ((col / 7 > 3) ? 3 : col / 7));
    status = {~code[4:0], 3'b000};
    if (s) status[1] = 1'b1;
    row = (y < 16) ? (16'h0001 << y[3:0]) : 16'h0000;
    bits = s ? {row, 16'h0000, status} : {16'h0000, row, status};
    pulse = h ? 16'h0000 : (s ? regs_now.set_pulse_us : regs_now.reset_pulse_us);
    next_frames[next_count] = '{FRAME_DRIVE, bits, pulse, h, 1'b1};
    next_count++;
  endfunction

  function automatic step_t reg_row(input logic [2:0] idx, input logic [15:0] d);
    step_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic step_t pix(input logic [7:0] x, y, input logic s, h);
    step_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.x = x;
    r.y = y;
    r.s = s;
    r.h = h;
    return r;
  endfunction

  function automatic step_t typed_row(input logic [7:0] x, y, input logic s, h,
                                      input logic [1:0] nres, input logic [7:0] sel,
                                      input logic [39:0] drv, input logic [15:0] pulse,
                                      input logic keep);
    step_t r;
    r = pix(x, y, s, h);
    r.kind = ROW_TYPED;
    r.nres = nres;
    r.sel = sel;
    r.drv = drv;
    r.pulse = pulse;
    r.keep = keep;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODULE_WIDTH:   regs_now.mod_cols = d[4:0];
      REG_MODULE_HEIGHT:  regs_now.mod_rows = d[4:0];
      REG_MODULE_COUNT:   regs_now.module_count = d[3:0];
      REG_SET_PULSE_US:   regs_now.set_pulse_us = d;
      REG_RESET_PULSE_US: regs_now.reset_pulse_us = d;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, let every expected frame drain, then cover commands that yield none
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] x, y, input logic s, h);
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    show <= s;
    hold <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    predict_pixel(x, y, s, h);
    if (next_count > 0) pixels_drawn++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    step_t       plan [$];
    int          phase, phase_all, phase_drawn, random_sent, burst_left, before_drawn;
    bit          steady;
    int unsigned mods, span;
    logic [7:0]  rx, ry;
    logic [15:0] v;

    regs_now = '{5'd28, 5'd16, 4'd1, 16'h0000, 16'h0000};
    sel_module = 4'd0;

    plan = '{
      // reset settings: one 28-column module, 16 rows, zero pulses
      typed_row(8'd0, 8'd0, 1'b1, 1'b0, 2'd2, 8'h01, 40'h00010000F2, 16'h0, 1'b0),
      typed_row(8'd27, 8'd15, 1'b0, 1'b0, 2'd1, 8'h00, 40'h0000800000, 16'h0, 1'b0),
      typed_row(8'd28, 8'd0, 1'b1, 1'b0, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      typed_row(8'd0, 8'd16, 1'b0, 1'b0, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      typed_row(8'd255, 8'd255, 1'b1, 1'b1, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      typed_row(8'd0, 8'd0, 1'b1, 1'b1, 2'd1, 8'h00, 40'h00010000F2, 16'h0, 1'b1),
      // widest and tallest modules, module count clamped to the maximum
      reg_row(REG_MODULE_WIDTH, 16'd31),
      reg_row(REG_MODULE_HEIGHT, 16'd31),
      reg_row(REG_MODULE_COUNT, 16'd15),
      reg_row(REG_SET_PULSE_US, 16'hFFFF),
      reg_row(REG_RESET_PULSE_US, 16'h0001),
      pix(8'd247, 8'd30, 1'b1, 1'b0),
      pix(8'd30, 8'd0, 1'b0, 1'b0),
      pix(8'd28, 8'd5, 1'b1, 1'b0),
      pix(8'd248, 8'd0, 1'b1, 1'b0),
      pix(8'd31, 8'd31, 1'b0, 1'b0),
      pix(8'd31, 8'd15, 1'b0, 1'b1),
      pix(8'd62, 8'd16, 1'b1, 1'b1),
      // one-column modules, single row
      reg_row(REG_MODULE_WIDTH, 16'd1),
      reg_row(REG_MODULE_COUNT, 16'd8),
      reg_row(REG_MODULE_HEIGHT, 16'd1),
      pix(8'd7, 8'd0, 1'b1, 1'b0),
      pix(8'd0, 8'd0, 1'b0, 1'b0),
      pix(8'd8, 8'd0, 1'b1, 1'b0),
      pix(8'd3, 8'd0, 1'b1, 1'b1),
      // empty displays
      reg_row(REG_MODULE_WIDTH, 16'd0),
      reg_row(REG_MODULE_HEIGHT, 16'd16),
      typed_row(8'd0, 8'd0, 1'b1, 1'b0, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      reg_row(REG_MODULE_WIDTH, 16'd5),
      reg_row(REG_MODULE_COUNT, 16'd0),
      typed_row(8'd0, 8'd0, 1'b0, 1'b0, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      reg_row(REG_MODULE_COUNT, 16'd9),
      reg_row(REG_MODULE_HEIGHT, 16'd0),
      typed_row(8'd0, 8'd0, 1'b1, 1'b1, 2'd0, 8'h00, 40'h0, 16'h0, 1'b0),
      reg_row(REG_MODULE_HEIGHT, 16'd16),
      pix(8'd39, 8'd3, 1'b1, 1'b0),
      pix(8'd40, 8'd3, 1'b1, 1'b0),
      pix(8'd14, 8'd7, 1'b0, 1'b1)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i-1].kind != ROW_REG) wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].x, plan[i].y, plan[i].s, plan[i].h);
        if (plan[i].kind == ROW_TYPED) begin
          if (plan[i].nres == 2)
            frames_due.push_back('{FRAME_SELECT, {32'h0, plan[i].sel}, 16'h0, 1'b0, 1'b0});
          if (plan[i].nres != 0)
            frames_due.push_back('{FRAME_DRIVE, plan[i].drv, plan[i].pulse,
                                   plan[i].keep, 1'b1});
        end else begin
          for (int k = 0; k < next_count; k++) frames_due.push_back(next_frames[k]);
        end
        pause($urandom_range(0, 3));
      end
    end

    before_drawn = pixels_drawn;
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: v = 16'd1;
        1: v = 16'd31;
        2: v = 16'd28;
        9: v = 16'd0;
        default: v = 16'($urandom_range(2, 30));
      endcase
      write_reg(REG_MODULE_WIDTH, v | (16'($urandom) & 16'hFFE0));
      case ($urandom_range(0, 11))
        0: v = 16'd1;
        1: v = 16'd16;
        2: v = 16'd31;
        11: v = 16'd0;
        default: v = 16'($urandom_range(2, 20));
      endcase
      write_reg(REG_MODULE_HEIGHT, v | (16'($urandom) & 16'hFFE0));
      case ($urandom_range(0, 11))
        0: v = 16'd1;
        1: v = 16'd8;
        2: v = 16'd15;
        11: v = 16'd0;
        default: v = 16'($urandom_range(1, 15));
      endcase
      write_reg(REG_MODULE_COUNT, v | (16'($urandom) & 16'hFFF0));
      case ($urandom_range(0, 3))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      write_reg(REG_SET_PULSE_US, v);
      case ($urandom_range(0, 3))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      write_reg(REG_RESET_PULSE_US, v);

      mods = (regs_now.module_count > MAX_MODULES) ? MAX_MODULES : regs_now.module_count;
      span = regs_now.mod_cols * mods;
      if (span > 256) span = 256;
      steady = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 20);
      phase_all = 0;
      phase_drawn = 0;
      while (phase_drawn < PHASE_ITEMS && phase_all < 120 && random_sent < RANDOM_ITEMS) begin
        // mostly commands that land on the display, the rest anywhere
        if (span != 0 && regs_now.mod_rows != 0 && $urandom_range(0, 99) < 85) begin
          rx = 8'($urandom_range(0, span - 1));
          ry = 8'($urandom_range(0, regs_now.mod_rows - 1));
        end else begin
          rx = 8'($urandom_range(0, 255));
          ry = 8'($urandom_range(0, 255));
        end
        send_pixel(rx, ry, 1'($urandom), 1'($urandom));
        for (int k = 0; k < next_count; k++) frames_due.push_back(next_frames[k]);
        phase_all++;
        random_sent++;
        if (next_count > 0) phase_drawn++;
        if (phase == 2 && phase_all == 20) begin
          // hold off until the block has delivered everything
          in_valid <= 1'b0;
          @(posedge clk);
          while (frames_due.size() != 0) @(posedge clk);
        end else if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            pause($urandom_range(1, 12));
          end
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 8) @(posedge clk);

    $display("sent %0d pixel commands (%0d on the display, %0d in random phases)",
             pixels_sent, pixels_drawn, pixels_drawn - before_drawn);
    $display("checked %0d frames over %0d register writes in %0d random phases",
             frames_checked, reg_writes, phase);
    if (errors == 0) begin
      $display("flipdot_pixel_frame_encoder test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("flipdot_pixel_frame_encoder test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fpfe_pkg.sv
rtl/core/fpfe_front.sv
rtl/core/fpfe_queue.sv
rtl/core/fpfe_back.sv
rtl/core/flipdot_pixel_frame_encoder.sv
tb/sv/tb_flipdot_pixel_frame_encoder.sv
